[design/fqr_pkg.sv]
package fqr_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_END   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
    logic [COUNT_W-1:0]       count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] value_res;
    logic                     last;
  } out_item_t;

endpackage

[design/fqr_ram.sv]
module fqr_ram #(
  parameter int unsigned DEPTH = fqr_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [fqr_pkg::WORD_W-1:0]       wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic [fqr_pkg::WORD_W-1:0]       rd_data
);

  logic [fqr_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/fifo_queue_with_readout_unit.sv]
// FIFO of signed 32-bit words in a ring of DEPTH entries, with dequeue and a
// non-destructive readout of the oldest entries. An enqueue is written into
// the ring when it is accepted. A dequeue gives one data item, a readout of N
// entries N data items plus an end-early status when N exceeds the occupancy,
// and a command on a full or empty queue a status item. Data items are paced
// by the single registered read port of the entry store, which the sequencer
// walks one entry per cycle while the output is not stalled; a status item
// waits in S_EMIT until the output register is free. in_ready is low while a
// dequeue, readout or status item is in progress; a stalled output stretches it further.
module fifo_queue_with_readout_unit #(
  parameter int unsigned DEPTH = fqr_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fqr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fqr_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = fqr_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                    state;
  logic [AW-1:0]                 head;
  logic [AW-1:0]                 tail;
  logic [OW-1:0]                 occ;
  logic [AW-1:0]                 ptr;
  logic [OW-1:0]                 remaining;
  logic                          early;
  logic                          pop;
  logic [fqr_pkg::STATUS_W-1:0]  pend_status;

  logic                          accept;
  logic                          slot_free;
  logic                          emit;
  logic                          is_full;
  logic                          is_empty;
  logic                          wr_en;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [fqr_pkg::WORD_W-1:0]    rd_data;
  logic [CW-1:0]                 occ_c;
  logic [OW-1:0]                 listed;
  logic                          over;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && ((state == S_DATA) || (state == S_EMIT));
  assign is_full   = (occ == OW'(DEPTH));
  assign is_empty  = (occ == '0);

  // readout length: count zero or at/above occupancy lists everything
  assign occ_c  = CW'(occ);
  assign over   = (in_item.count != '0) && (in_item.count > occ_c);
  assign listed = ((in_item.count == '0) || (in_item.count >= occ_c))
                  ? occ : OW'(in_item.count);

  assign wr_en = accept && (in_item.kind == fqr_pkg::KIND_ENQ) && !is_full;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (accept && !is_empty &&
        ((in_item.kind == fqr_pkg::KIND_DEQ) || (in_item.kind == fqr_pkg::KIND_READ))) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if (state == S_DATA && slot_free && remaining != OW'(1)) begin
      rd_en   = 1'b1;
      rd_addr = ring_inc(ptr);
    end
  end

  fqr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (in_item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_item.kind)
              fqr_pkg::KIND_ENQ: begin
                if (is_full) begin
                  pend_status <= fqr_pkg::STAT_FULL;
                  state       <= S_EMIT;
                end else begin
                  tail <= ring_inc(tail);
                  occ  <= occ + 1'b1;
                end
              end
              fqr_pkg::KIND_DEQ, fqr_pkg::KIND_READ: begin
                if (is_empty) begin
                  pend_status <= fqr_pkg::STAT_EMPTY;
                  state       <= S_EMIT;
                end else begin
                  ptr   <= head;
                  pop   <= (in_item.kind == fqr_pkg::KIND_DEQ);
                  early <= (in_item.kind == fqr_pkg::KIND_READ) && over;
                  remaining <= (in_item.kind == fqr_pkg::KIND_DEQ) ? OW'(1) : listed;
                  state <= S_DATA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DATA: begin
          if (slot_free) begin
            out_item.status    <= fqr_pkg::STAT_DATA;
            out_item.value_res <= rd_data;
            out_item.last      <= (remaining == OW'(1)) && !early;
            remaining          <= remaining - 1'b1;
            ptr                <= ring_inc(ptr);
            if (remaining == OW'(1)) begin
              if (pop) begin
                head <= ring_inc(head);
                occ  <= occ - 1'b1;
              end
              if (early) begin
                pend_status <= fqr_pkg::STAT_END;
                state       <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_item.status    <= pend_status;
            out_item.value_res <= '0;
            out_item.last      <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    ((({1'b0, head} + (AW+1)'(occ)) < (AW+1)'(DEPTH)) &&
     ((AW+1)'(tail) == {1'b0, head} + (AW+1)'(occ))) ||
    ((({1'b0, head} + (AW+1)'(occ)) >= (AW+1)'(DEPTH)) &&
     ((AW+1)'(tail) == {1'b0, head} + (AW+1)'(occ) - (AW+1)'(DEPTH))))
    else $error("head, tail and occupancy disagree");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (remaining != '0) && (remaining <= occ))
    else $error("readout walk out of range");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != fqr_pkg::STAT_DATA) |->
      (out_item.value_res == '0) && out_item.last)
    else $error("status item not clean");

endmodule

[tb/fifo_queue_with_readout_unit_tb.sv]
module fifo_queue_with_readout_unit_tb;
  import fqr_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 390;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MAX_PRINTED = 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;

  fifo_queue_with_readout_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  // queue model
  logic signed [WORD_W-1:0] model_words [DEPTH];
  int unsigned model_head;
  int unsigned model_tail;
  int unsigned model_count;
  out_item_t pending_results [$];

  int unsigned error_count;
  int unsigned commands_sent;
  int unsigned ignored_commands;
  int unsigned results_checked;
  int unsigned full_drops;
  int unsigned early_ends;
  int unsigned longest_listing;

  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  task automatic expect_result(input logic [STATUS_W-1:0] status,
                               input logic signed [WORD_W-1:0] word,
                               input logic last);
    out_item_t r;
    r.status = status;
    r.value_res = word;
    r.last = last;
    pending_results.push_back(r);
  endtask

  task automatic apply_command(input in_item_t cmd);
    int unsigned listed;
    bit early;
    case (cmd.kind)
      KIND_ENQ: begin
        if (model_count == DEPTH) begin
          expect_result(STAT_FULL, '0, 1'b1);
          full_drops++;
        end else begin
          model_words[model_tail] = cmd.value;
          model_tail = (model_tail + 1) % DEPTH;
          model_count++;
        end
      end
      KIND_DEQ: begin
        if (model_count == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          expect_result(STAT_DATA, model_words[model_head], 1'b1);
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      KIND_READ: begin
        if (model_count == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          early = 1'b0;
          if (cmd.count == 0 || cmd.count == model_count) begin
            listed = model_count;
          end else if (cmd.count < model_count) begin
            listed = cmd.count;
          end else begin
            listed = model_count;
            early = 1'b1;
          end
          for (int unsigned i = 0; i < listed; i++) begin
            expect_result(STAT_DATA, model_words[(model_head + i) % DEPTH],
                          !early && (i + 1 == listed));
          end
          if (early) begin
            expect_result(STAT_END, '0, 1'b1);
            early_ends++;
          end
          if (listed > longest_listing) longest_listing = listed;
        end
      end
      default: begin
        ignored_commands++;
      end
    endcase
  endtask

  // valid stays high across back-to-back items; dropped only when a gap is drawn
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [WORD_W-1:0] word,
                           input logic [COUNT_W-1:0] count);
    int unsigned gap;
    in_item_t cmd;
    gap = $urandom_range(0, send_gap_max);
    cmd.kind = kind;
    cmd.value = word;
    cmd.count = count;
    @(negedge clk);
    for (int unsigned i = 0; i < gap; i++) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item = cmd;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
    apply_command(cmd);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: per-result stall, plus a long hold when requested
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      stall_left = $urandom_range(0, recv_gap_max);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                  out_item.status, out_item.value_res, out_item.last));
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_item.status, want.status));
        if (out_item.value_res !== want.value_res)
          report_mismatch($sformatf("value_res %0d, expected %0d",
                                    out_item.value_res, want.value_res));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_item.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a handshake, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("[fifo_queue_with_readout_unit] ERROR");
      $finish;
    end
  end

  task automatic test_empty_queue();
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_READ, '0, 6'd0);
    send_item(KIND_READ, 32'h7fff_ffff, 6'd63);
    send_item(KIND_UNUSED, 32'hffff_ffff, 6'd63);
  endtask

  task automatic test_readout_counts();
    send_item(KIND_ENQ, 32'sh8000_0000, 6'd63);
    send_item(KIND_ENQ, 32'sh7fff_ffff, '0);
    send_item(KIND_ENQ, '0, 6'd21);
    send_item(KIND_ENQ, -32'sd1, 6'd42);
    send_item(KIND_ENQ, 32'sh5555_aaaa, '0);
    send_item(KIND_READ, '0, 6'd0);
    send_item(KIND_READ, '0, 6'd1);
    send_item(KIND_READ, '0, 6'd5);
    send_item(KIND_READ, '0, 6'd6);
    send_item(KIND_READ, 32'hffff_ffff, 6'd63);
    send_item(KIND_DEQ, 32'hffff_ffff, 6'd63);
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_UNUSED, '0, '0);
    send_item(KIND_READ, '0, 6'd3);
  endtask

  // fill while the output is held so the readout backs up into the input
  task automatic test_full_under_backpressure();
    wait_drain();
    send_gap_max = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    while (model_count < DEPTH) send_item(KIND_ENQ, $urandom, COUNT_W'($urandom));
    send_item(KIND_ENQ, 32'sh1234_5678, '0);
    send_item(KIND_READ, '0, 6'd0);
    send_item(KIND_READ, '0, 6'd63);
    send_item(KIND_ENQ, -32'sd7, 6'd1);
    send_item(KIND_READ, '0, 6'(DEPTH));
    send_item(KIND_DEQ, '0, '0);
    send_item(KIND_READ, '0, 6'(DEPTH));
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned block_left;
    int unsigned mode;
    int unsigned roll;
    int unsigned enq_cut;
    int unsigned deq_cut;
    int unsigned read_cut;
    logic [KIND_W-1:0] kind;
    logic [COUNT_W-1:0] count;
    sent = 0;
    block_left = 0;
    mode = 0;
    while (sent < RANDOM_ITEMS) begin
      if (block_left == 0) begin
        block_left = $urandom_range(20, 50);
        mode = $urandom_range(0, 2);
        send_gap_max = $urandom_range(0, 2) == 0 ? 0 : 13;
        recv_gap_max = $urandom_range(0, 2) == 0 ? 0 : 13;
        if ($urandom_range(0, 3) == 0) wait_drain();
      end
      block_left--;
      // modes: filling, draining, balanced
      case (mode)
        0: begin enq_cut = 70; deq_cut = 82; read_cut = 97; end
        1: begin enq_cut = 25; deq_cut = 65; read_cut = 96; end
        default: begin enq_cut = 45; deq_cut = 70; read_cut = 96; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < enq_cut) kind = KIND_ENQ;
      else if (roll < deq_cut) kind = KIND_DEQ;
      else if (roll < read_cut) kind = KIND_READ;
      else kind = KIND_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 15) count = '0;
      else if (roll < 70) count = COUNT_W'($urandom_range(0, model_count + 2));
      else count = COUNT_W'($urandom);
      send_item(kind, $urandom, count);
      if (kind != KIND_UNUSED) sent++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    send_gap_max = 0;
    recv_gap_max = 0;
    error_count = 0;
    commands_sent = 0;
    ignored_commands = 0;
    results_checked = 0;
    full_drops = 0;
    early_ends = 0;
    longest_listing = 0;
    quiet_cycles = 0;
    model_head = 0;
    model_tail = 0;
    model_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    send_gap_max = 13;
    recv_gap_max = 13;
    test_readout_counts();
    test_full_under_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands (%0d of the unused kind), checked %0d results.",
             commands_sent, ignored_commands, results_checked);
    $display("Saw %0d drops on a full queue, %0d early ends, longest listing %0d words.",
             full_drops, early_ends, longest_listing);
    if (error_count == 0) begin
      $display("[fifo_queue_with_readout_unit] OK");
    end else begin
      $display("[fifo_queue_with_readout_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/fqr_pkg.sv
design/fqr_ram.sv
design/fifo_queue_with_readout_unit.sv
tb/fifo_queue_with_readout_unit_tb.sv
